@@ src/sudiv_pkg.sv @@
// Shared types and constants for the signed/unsigned integer divider.
// Used by every module under src; depends on nothing.
`default_nettype none

package sudiv_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned StepWidth  = $clog2(DataWidth);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Operation select codes carried in the func field.
  localparam logic FuncSigned   = 1'b0;
  localparam logic FuncUnsigned = 1'b1;

  typedef struct packed {
    logic                 func;
    logic [DataWidth-1:0] dividend;
    logic [DataWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [DataWidth-1:0]  quotient;
    logic                  div_by_zero;
    logic [CountWidth-1:0] unsigned_count;
    logic [CountWidth-1:0] signed_count;
  } div_rsp_t;

  // A classified job as handed from the front end to the back end.
  typedef struct packed {
    logic                 is_unsigned;
    logic                 by_zero;
    logic                 neg_result;
    logic [DataWidth-1:0] mag_a;
    logic [DataWidth-1:0] mag_b;
  } div_job_t;

endpackage

`default_nettype wire

@@ src/sudiv_front.sv @@
// Front end of the divider: takes request transactions and classifies them.
// Detects a zero divisor, works out the result sign and operand magnitudes.
// Depends on sudiv_pkg.
`default_nettype none

module sudiv_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  req_valid_i,
  output logic                 req_ready_o,
  input  sudiv_pkg::div_req_t  req_i,
  output logic                 job_valid_o,
  input  wire                  job_ready_i,
  output sudiv_pkg::div_job_t  job_o
);

  logic                valid_q;
  sudiv_pkg::div_job_t job_q;
  sudiv_pkg::div_job_t job_d;
  logic                neg_a;
  logic                neg_b;

  always_comb begin
    neg_a = (req_i.func == sudiv_pkg::FuncSigned) && req_i.dividend[sudiv_pkg::DataWidth-1];
    neg_b = (req_i.func == sudiv_pkg::FuncSigned) && req_i.divisor[sudiv_pkg::DataWidth-1];
    job_d.is_unsigned = (req_i.func == sudiv_pkg::FuncUnsigned);
    job_d.by_zero     = (req_i.divisor == '0);
    job_d.neg_result  = neg_a ^ neg_b;
    job_d.mag_a       = neg_a ? (~req_i.dividend + 1'b1) : req_i.dividend;
    job_d.mag_b       = neg_b ? (~req_i.divisor + 1'b1) : req_i.divisor;
  end

  assign req_ready_o = !valid_q || job_ready_i;
  assign job_valid_o = valid_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_ready_o) begin
      valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready_o && req_valid_i) begin
      job_q <= job_d;
    end
  end

endmodule

`default_nettype wire

@@ src/sudiv_queue.sv @@
// Short job queue between the divider front end and back end.
// Flip-flop storage, depth set by QueueDepth (a power of two); depends on sudiv_pkg.
`default_nettype none

module sudiv_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  wr_valid_i,
  output logic                 wr_ready_o,
  input  sudiv_pkg::div_job_t  wr_job_i,
  output logic                 rd_valid_o,
  input  wire                  rd_ready_i,
  output sudiv_pkg::div_job_t  rd_job_o
);

  sudiv_pkg::div_job_t             mem_q [sudiv_pkg::QueueDepth];
  logic [sudiv_pkg::QueuePtrW-1:0] wr_ptr_q;
  logic [sudiv_pkg::QueuePtrW-1:0] rd_ptr_q;
  logic [sudiv_pkg::QueuePtrW:0]   level_q;
  logic                            push;
  logic                            pop;

  assign wr_ready_o = (level_q != (sudiv_pkg::QueuePtrW+1)'(sudiv_pkg::QueueDepth));
  assign rd_valid_o = (level_q != '0);
  assign rd_job_o   = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        level_q <= level_q + 1'b1;
      end else if (pop && !push) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

`default_nettype wire

@@ src/sudiv_back.sv @@
// Back end of the divider: radix-2 restoring divide, sign fixup, usage counters
// and the result register. Depends on sudiv_pkg.
`default_nettype none

module sudiv_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  job_valid_i,
  output logic                 job_ready_o,
  input  sudiv_pkg::div_job_t  job_i,
  output logic                 rsp_valid_o,
  input  wire                  rsp_ready_i,
  output sudiv_pkg::div_rsp_t  rsp_o
);

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StDone
  } state_e;

  localparam int unsigned W = sudiv_pkg::DataWidth;

  state_e                             state_q;
  logic                               is_unsigned_q;
  logic                               by_zero_q;
  logic                               neg_result_q;
  logic [W-1:0]                       rem_q;
  logic [W-1:0]                       quo_q;
  logic [W-1:0]                       div_q;
  logic [sudiv_pkg::StepWidth-1:0]    step_q;
  logic [sudiv_pkg::CountWidth-1:0]   ucnt_q;
  logic [sudiv_pkg::CountWidth-1:0]   scnt_q;
  logic [sudiv_pkg::CountWidth-1:0]   ucnt_d;
  logic [sudiv_pkg::CountWidth-1:0]   scnt_d;
  logic                               rsp_valid_q;
  sudiv_pkg::div_rsp_t                rsp_q;
  logic [W:0]                         shifted;
  logic [W+1:0]                       trial;
  logic                               slot_free;

  // One restoring step: bring in the next dividend bit and try to subtract.
  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    trial   = {1'b0, shifted} - {2'b00, div_q};
  end

  always_comb begin
    ucnt_d = ucnt_q;
    scnt_d = scnt_q;
    if (!by_zero_q) begin
      if (is_unsigned_q) begin
        ucnt_d = ucnt_q + 1'b1;
      end else begin
        scnt_d = scnt_q + 1'b1;
      end
    end
  end

  assign slot_free   = !rsp_valid_q || rsp_ready_i;
  assign job_ready_o = (state_q == StIdle);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rsp_valid_q <= 1'b0;
      ucnt_q      <= '0;
      scnt_q      <= '0;
    end else begin
      // In StDone a taken response is replaced by the next one below.
      if (rsp_valid_q && rsp_ready_i && (state_q != StDone)) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            state_q <= job_i.by_zero ? StDone : StCalc;
          end
        end
        StCalc: begin
          if (step_q == '0) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (slot_free) begin
            rsp_valid_q <= 1'b1;
            ucnt_q      <= ucnt_d;
            scnt_q      <= scnt_d;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          is_unsigned_q <= job_i.is_unsigned;
          by_zero_q     <= job_i.by_zero;
          neg_result_q  <= job_i.neg_result;
          rem_q         <= '0;
          quo_q         <= job_i.mag_a;
          div_q         <= job_i.mag_b;
          step_q        <= sudiv_pkg::StepWidth'(W - 1);
        end
      end
      StCalc: begin
        step_q <= step_q - 1'b1;
        if (trial[W+1]) begin
          rem_q <= shifted[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b0};
        end else begin
          rem_q <= trial[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b1};
        end
      end
      StDone: begin
        if (slot_free) begin
          if (by_zero_q) begin
            rsp_q.quotient <= '0;
          end else if (neg_result_q) begin
            rsp_q.quotient <= ~quo_q + 1'b1;
          end else begin
            rsp_q.quotient <= quo_q;
          end
          rsp_q.div_by_zero    <= by_zero_q;
          rsp_q.unsigned_count <= ucnt_d;
          rsp_q.signed_count   <= scnt_d;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/signed_unsigned_int_divider.sv @@
// Signed/unsigned 32-bit integer divider with running usage counts.
//
// Request channel (in_valid_i/in_ready_o/in_data_i) carries func, dividend and
// divisor; response channel (out_valid_o/out_ready_i/out_data_o) returns the
// truncated quotient, a divide-by-zero flag and both usage counts, one response
// per request, in order. The most negative value divided by minus one returns
// the most negative value. A zero divisor gives quotient zero, sets the flag
// and leaves both counts unchanged.
//
// A front stage classifies each request into a registered job and passes it
// through a two-entry job queue to the back end. The back end loads the job,
// runs its shared restoring subtractor (one quotient bit per cycle) and does
// sign fixup into the response register; a zero divisor skips the subtractor.
// The back end takes a new job only once the previous divide has reached the
// response register.
// While a response waits for out_ready_i, the back end finishes its current
// divide and holds it; the front end and queue keep taking requests until full.
// Reset clears both counts, the queue and all valid flags.
// Depends on sudiv_pkg, sudiv_front, sudiv_queue and sudiv_back.
`default_nettype none

module signed_unsigned_int_divider (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  sudiv_pkg::div_req_t  in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output sudiv_pkg::div_rsp_t  out_data_o
);

  logic                fr_valid;
  logic                fr_ready;
  sudiv_pkg::div_job_t fr_job;
  logic                bk_valid;
  logic                bk_ready;
  sudiv_pkg::div_job_t bk_job;

  sudiv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_data_i),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_o       (fr_job)
  );

  sudiv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_job_i   (fr_job),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_job_o   (bk_job)
  );

  sudiv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bk_valid),
    .job_ready_o (bk_ready),
    .job_i       (bk_job),
    .rsp_valid_o (out_valid_o),
    .rsp_ready_i (out_ready_i),
    .rsp_o       (out_data_o)
  );

`ifndef ASSERT_OFF
  // A divide by zero never reports a nonzero quotient.
  a_zero_quotient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.div_by_zero) |-> (out_data_o.quotient == '0))
    else $error("divide by zero returned a nonzero quotient");

  // A classified job held by the front end is not lost while the queue is full.
  a_front_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_valid && !fr_ready) |=> (fr_valid && $stable(fr_job)))
    else $error("front end dropped or changed a stalled job");

  // A new response moves at most one of the two counts.
  a_one_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !(out_data_o.unsigned_count != $past(out_data_o.unsigned_count, 2)
      && out_data_o.signed_count != $past(out_data_o.signed_count, 2)
      && $past(out_valid_o, 2)))
    else $error("one response advanced both counts");
`endif

endmodule

`default_nettype wire
